>>> rtl/bfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfe_pkg
// Widths, fixed constants and the double factorial table of the Boys
// function evaluator.
// ----------------------------------------------------------------------------
package bfe_pkg;

	localparam int N_W    = 4;
	localparam int X_W    = 32;
	localparam int ASYM_W = 48;
	localparam int SER_W  = 49;
	localparam int EXP_W  = 12;
	localparam int SER_SHIFT = 26;

	localparam logic [63:0] PI_MANT  = 64'h6487_ED51_10B4_611A;
	localparam logic [63:0] NORM_BIT = 64'h4000_0000_0000_0000;
	localparam logic [63:0] SER_ONE  = 64'h0400_0000_0000_0000;
	localparam logic [63:0] SER_TOL  = 64'd28823;
	localparam logic [63:0] ZERO_NUM = 64'h0000_0001_0000_0000;
	localparam logic [X_W-1:0] X_FOUR = 32'h0400_0000;
	localparam logic [ASYM_W-1:0] ASYM_MAX = 48'hFFFF_FFFF_FFFF;

	localparam logic signed [EXP_W-1:0] PI_EXP   = -12'sd61;
	localparam logic signed [EXP_W-1:0] X_EXP    = -12'sd24;
	localparam logic signed [EXP_W-1:0] MUL_BIAS = 12'sd62;
	localparam logic signed [EXP_W-1:0] OUT_BIAS = 12'sd32;

	// (2n-1)!!, with (-1)!! = 1
	function automatic logic [63:0] dfact(input logic [N_W-1:0] n);
		logic [63:0] v;
		case (n)
			4'd0:    v = 64'd1;
			4'd1:    v = 64'd1;
			4'd2:    v = 64'd3;
			4'd3:    v = 64'd15;
			4'd4:    v = 64'd105;
			4'd5:    v = 64'd945;
			4'd6:    v = 64'd10395;
			4'd7:    v = 64'd135135;
			4'd8:    v = 64'd2027025;
			4'd9:    v = 64'd34459425;
			4'd10:   v = 64'd654729075;
			4'd11:   v = 64'd13749310575;
			4'd12:   v = 64'd316234143225;
			4'd13:   v = 64'd7905853580625;
			4'd14:   v = 64'd213458046676875;
			4'd15:   v = 64'd6190283353629375;
			default: v = 64'd1;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/boys_function_evaluator_top.sv
// The asymptotic estimate is always made, on its own short path when x = 0; the series adds
// up to MAX_TERMS terms when x <= 4.
// One beat is taken at a time; the pace is set by the bit-serial 63-step divider, the
// 32-step square root and the 8-bit-per-cycle small divider of the series.
// Reset: arst_n clears the sequencer, the output register and order_q to 0.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boys_function_evaluator_top
// Asymptotic and series estimates of F_n(x) on one shared iterative datapath.
// ----------------------------------------------------------------------------
module boys_function_evaluator_top import bfe_pkg::*; #(
	parameter int MAX_TERMS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [N_W-1:0]          cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [X_W-1:0]          arg_x,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ASYM_W-1:0]       asymptotic_value,
	output logic signed [SER_W-1:0] series_value,
	output logic                    series_valid,
	output logic                    saturated
);

	localparam int K_W   = $clog2(MAX_TERMS);
	localparam int DIV_W = $clog2(2 * ((1 << N_W) - 1) + 2 * MAX_TERMS);

	typedef enum logic [4:0] {
		S_IDLE, S_NORM, S_XSAVE, S_BDIV, S_SQRT_INIT, S_SQRT, S_LOOP, S_MUL,
		S_ASYM, S_SDIV, S_ZERO, S_SERIES, S_TSTART, S_TERM, S_SMUL0, S_SMUL1,
		S_UNEXT, S_OUT
	} state_t;

	state_t state_q, ret_q;

	logic [N_W-1:0]          order_q, n_q, idx_q;
	logic [X_W-1:0]          x_q;
	logic [63:0]             mant_q, xm_q, rem_q, quo_q;
	logic signed [EXP_W-1:0] exp_q, xe_q;
	logic [5:0]              cnt_q;
	logic [127:0]            acc_q;
	logic [63:0]             sd_num_q;
	logic [DIV_W-1:0]        sd_rem_q, sd_den_q;
	logic [63:0]             u_q, sum_q, w_q;
	logic [K_W-1:0]          k_q;
	logic [ASYM_W-1:0]       asym_q, aval_q;
	logic [SER_W-1:0]        ser_q, sval_q;
	logic                    ok_q, sat_q, okout_q, satout_q, outv_q;

	// normaliser, one place a cycle
	logic [63:0]             nm;
	logic signed [EXP_W-1:0] ne;
	logic                    norm_done;

	always_comb begin
		nm = mant_q;
		ne = exp_q;
		norm_done = 1'b0;
		if (mant_q == '0) begin
			nm = NORM_BIT;
		end else if (mant_q[63]) begin
			nm = mant_q >> 1;
			ne = exp_q + 12'sd1;
		end else if (!mant_q[62]) begin
			nm = mant_q << 1;
			ne = exp_q - 12'sd1;
		end else begin
			norm_done = 1'b1;
		end
	end

	// restoring divider, one quotient bit a cycle
	logic        bd_ge;
	logic [63:0] bd_diff, bd_rem_n, bd_quo_n;

	assign bd_ge    = rem_q >= xm_q;
	assign bd_diff  = bd_ge ? rem_q - xm_q : rem_q;
	assign bd_rem_n = bd_diff << 1;
	assign bd_quo_n = {quo_q[62:0], bd_ge};

	// square root, one result bit a cycle
	logic [63:0]             sq_bit, sq_trial, sq_rem_n, sq_res_n, sq_v;
	logic                    sq_ge;
	logic signed [EXP_W-1:0] sq_e;

	assign sq_bit   = 64'd1 << (6'd62 - {cnt_q[4:0], 1'b0});
	assign sq_trial = quo_q + sq_bit;
	assign sq_ge    = rem_q >= sq_trial;
	assign sq_rem_n = sq_ge ? rem_q - sq_trial : rem_q;
	assign sq_res_n = sq_ge ? (quo_q >> 1) + sq_bit : quo_q >> 1;
	assign sq_v     = exp_q[0] ? mant_q >> 1 : mant_q;
	assign sq_e     = exp_q[0] ? exp_q + 12'sd1 : exp_q;

	// shared 32x32 multiplier
	logic [31:0]  mul_a, mul_b;
	logic [63:0]  prod;
	logic [127:0] pp, acc_n;

	always_comb begin
		case (state_q)
			S_MUL: begin
				case (cnt_q[1:0])
					2'd0:    begin mul_a = xm_q[31:0];  mul_b = mant_q[31:0];  end
					2'd1:    begin mul_a = xm_q[31:0];  mul_b = mant_q[63:32]; end
					2'd2:    begin mul_a = xm_q[63:32]; mul_b = mant_q[31:0];  end
					default: begin mul_a = xm_q[63:32]; mul_b = mant_q[63:32]; end
				endcase
			end
			S_SMUL0: begin
				mul_a = u_q[63:32];
				mul_b = x_q;
			end
			default: begin
				mul_a = u_q[31:0];
				mul_b = x_q;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    pp = {64'd0, prod};
			2'd3:    pp = {prod, 64'd0};
			default: pp = {32'd0, prod, 32'd0};
		endcase
	end

	assign acc_n = acc_q + pp;

	// small divider, eight quotient bits a cycle
	logic [63:0] sd_num_n;
	logic [DIV_W-1:0] sd_rem_n;

	always_comb begin
		logic [DIV_W:0] r;
		logic [63:0]    q;
		r = {1'b0, sd_rem_q};
		q = sd_num_q;
		for (int j = 0; j < 8; j++) begin
			r = {r[DIV_W-1:0], q[63]};
			q = {q[62:0], 1'b0};
			if (r >= {1'b0, sd_den_q}) begin
				r = r - {1'b0, sd_den_q};
				q[0] = 1'b1;
			end
		end
		sd_num_n = q;
		sd_rem_n = r[DIV_W-1:0];
	end

	logic [DIV_W-1:0] den_t, den_u, den_z;

	assign den_t = DIV_W'({n_q, 1'b0}) + DIV_W'({k_q, 1'b0}) + DIV_W'(1);
	assign den_u = DIV_W'({1'b0, k_q}) + DIV_W'(1);
	assign den_z = DIV_W'({order_q, 1'b0}) + DIV_W'(1);

	// asymptotic result to Q16.32
	logic signed [EXP_W-1:0] a_sh, a_nsh;
	logic [63:0]             a_res;
	logic [ASYM_W-1:0]       a_val;
	logic                    a_sat;

	assign a_sh  = exp_q + OUT_BIAS;
	assign a_nsh = -a_sh;
	assign a_res = mant_q >> a_nsh[5:0];

	always_comb begin
		a_val = '0;
		a_sat = 1'b0;
		if (!a_sh[EXP_W-1]) begin
			a_val = ASYM_MAX;
			a_sat = 1'b1;
		end else if (a_nsh[EXP_W-1:6] != '0) begin
			a_val = '0;
		end else if (a_res > {16'd0, ASYM_MAX}) begin
			a_val = ASYM_MAX;
			a_sat = 1'b1;
		end else begin
			a_val = a_res[ASYM_W-1:0];
		end
	end

	// series term
	logic [63:0]        s_sum_n;
	logic signed [63:0] s_shr;
	logic               s_stop;

	assign s_sum_n = k_q[0] ? sum_q - sd_num_q : sum_q + sd_num_q;
	assign s_shr   = $signed(s_sum_n) >>> SER_SHIFT;
	assign s_stop  = (sd_num_q <= SER_TOL) || (k_q == K_W'(MAX_TERMS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			order_q  <= '0;
			n_q      <= '0;
			idx_q    <= '0;
			x_q      <= '0;
			mant_q   <= '0;
			exp_q    <= '0;
			xm_q     <= '0;
			xe_q     <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			cnt_q    <= '0;
			acc_q    <= '0;
			sd_num_q <= '0;
			sd_rem_q <= '0;
			sd_den_q <= '0;
			u_q      <= '0;
			sum_q    <= '0;
			w_q      <= '0;
			k_q      <= '0;
			asym_q   <= '0;
			ser_q    <= '0;
			ok_q     <= 1'b0;
			sat_q    <= 1'b0;
			aval_q   <= '0;
			sval_q   <= '0;
			okout_q  <= 1'b0;
			satout_q <= 1'b0;
			outv_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				order_q <= cfg_wr_data;
			end
			if (outv_q && out_ready && state_q != S_OUT) begin
				outv_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q   <= arg_x;
						n_q   <= order_q;
						idx_q <= '0;
						sat_q <= 1'b0;
						cnt_q <= '0;
						if (arg_x == '0) begin
							sd_num_q <= ZERO_NUM;
							sd_rem_q <= '0;
							sd_den_q <= den_z;
							ret_q    <= S_ZERO;
							state_q  <= S_SDIV;
						end else begin
							mant_q  <= {32'd0, arg_x};
							exp_q   <= X_EXP;
							ret_q   <= S_XSAVE;
							state_q <= S_NORM;
						end
					end
				end
				S_NORM: begin
					mant_q <= nm;
					exp_q  <= ne;
					if (norm_done) begin
						state_q <= ret_q;
					end
				end
				S_XSAVE: begin
					xm_q    <= mant_q;
					xe_q    <= exp_q;
					rem_q   <= PI_MANT;
					quo_q   <= '0;
					cnt_q   <= '0;
					exp_q   <= PI_EXP - exp_q - MUL_BIAS;
					ret_q   <= S_SQRT_INIT;
					state_q <= S_BDIV;
				end
				S_BDIV: begin
					rem_q <= bd_rem_n;
					quo_q <= bd_quo_n;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd62) begin
						mant_q  <= bd_quo_n;
						state_q <= S_NORM;
					end
				end
				S_SQRT_INIT: begin
					rem_q   <= sq_v;
					quo_q   <= '0;
					exp_q   <= sq_e >>> 1;
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					rem_q <= sq_rem_n;
					quo_q <= sq_res_n;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						mant_q  <= sq_res_n;
						ret_q   <= S_LOOP;
						state_q <= S_NORM;
					end
				end
				S_LOOP: begin
					cnt_q <= '0;
					if (idx_q != n_q) begin
						rem_q   <= mant_q;
						quo_q   <= '0;
						exp_q   <= exp_q - xe_q - MUL_BIAS;
						idx_q   <= idx_q + 1'b1;
						ret_q   <= S_LOOP;
						state_q <= S_BDIV;
					end else begin
						xm_q    <= mant_q;
						xe_q    <= exp_q;
						mant_q  <= dfact(n_q);
						exp_q   <= -$signed(EXP_W'(n_q)) - 12'sd1;
						acc_q   <= '0;
						ret_q   <= S_MUL;
						state_q <= S_NORM;
					end
				end
				S_MUL: begin
					acc_q <= acc_n;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[1:0] == 2'd3) begin
						mant_q  <= acc_n[125:62];
						exp_q   <= xe_q + exp_q + MUL_BIAS;
						ret_q   <= S_ASYM;
						state_q <= S_NORM;
					end
				end
				S_ASYM: begin
					asym_q  <= a_val;
					sat_q   <= a_sat;
					state_q <= S_SERIES;
				end
				S_SDIV: begin
					sd_num_q <= sd_num_n;
					sd_rem_q <= sd_rem_n;
					cnt_q    <= cnt_q + 6'd1;
					if (cnt_q[2:0] == 3'd7) begin
						state_q <= ret_q;
					end
				end
				S_ZERO: begin
					asym_q  <= sd_num_q[ASYM_W-1:0];
					state_q <= S_SERIES;
				end
				S_SERIES: begin
					if (x_q > X_FOUR) begin
						ser_q   <= '0;
						ok_q    <= 1'b0;
						state_q <= S_OUT;
					end else begin
						u_q     <= SER_ONE;
						sum_q   <= '0;
						k_q     <= '0;
						state_q <= S_TSTART;
					end
				end
				S_TSTART: begin
					sd_num_q <= u_q;
					sd_rem_q <= '0;
					sd_den_q <= den_t;
					cnt_q    <= '0;
					ret_q    <= S_TERM;
					state_q  <= S_SDIV;
				end
				S_TERM: begin
					sum_q <= s_sum_n;
					if (s_stop) begin
						ser_q   <= s_shr[SER_W-1:0];
						ok_q    <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_SMUL0;
					end
				end
				S_SMUL0: begin
					w_q     <= {prod[55:0], 8'd0};
					state_q <= S_SMUL1;
				end
				S_SMUL1: begin
					sd_num_q <= w_q + (prod >> 24);
					sd_rem_q <= '0;
					sd_den_q <= den_u;
					cnt_q    <= '0;
					ret_q    <= S_UNEXT;
					state_q  <= S_SDIV;
				end
				S_UNEXT: begin
					u_q     <= sd_num_q;
					k_q     <= k_q + 1'b1;
					state_q <= S_TSTART;
				end
				S_OUT: begin
					if (!outv_q || out_ready) begin
						aval_q   <= asym_q;
						sval_q   <= ser_q;
						okout_q  <= ok_q;
						satout_q <= sat_q;
						outv_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready         = state_q == S_IDLE;
	assign out_valid        = outv_q;
	assign asymptotic_value = aval_q;
	assign series_value     = $signed(sval_q);
	assign series_valid     = okout_q;
	assign saturated        = satout_q;

endmodule

>>> rtl/bfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfe_checker
// Port-level checks on the Boys function evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bfe_checker import bfe_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    cfg_wr_en,
	input logic [N_W-1:0]          cfg_wr_data,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic [X_W-1:0]          arg_x,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [ASYM_W-1:0]       asymptotic_value,
	input logic signed [SER_W-1:0] series_value,
	input logic                    series_valid,
	input logic                    saturated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(asymptotic_value)
			&& $stable(series_value) && $stable(series_valid) && $stable(saturated))
		else $error("result beat changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready again straight after an input beat");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> asymptotic_value == ASYM_MAX)
		else $error("saturated flag without clipped value");

	a_inval: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !series_valid |-> series_value == '0)
		else $error("series value not cleared when invalid");

endmodule

bind boys_function_evaluator_top bfe_checker u_bfe_checker (.*);
